@@ rtl/lsr_pkg.sv @@
// Package for the LIFO stack with in-place reverse.
// Holds the default sizes, the operation and status codes, the control states
// and the result word layout. It depends on nothing.
package lsr_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;
    localparam int RESULT_W = VALUE_W + OCC_W + 1 + STATUS_W;
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int S_DATA_W = VALUE_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_REVERSE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_REV_LO,
        ST_REV_HI
    } state_t;

    typedef struct packed {
        status_t            status;
        logic               is_empty;
        logic [OCC_W-1:0]   occupancy;
        logic [VALUE_W-1:0] popped_value;
    } result_t;

endpackage

@@ rtl/lifo_stack_with_reverse_top.sv @@
// Top level of the LIFO stack with in-place reverse.
// Connects lsr_ctrl to the entry memory lsr_mem; depends on lsr_pkg.
//
// Each word on the input asks for a push, a pop or a reverse of the whole
// stack, and each yields exactly one result word with the popped value, the
// occupancy after the operation, an empty flag and a status (underflow on a
// pop of an empty stack, overflow on a push to a full one, which is dropped).
// A push, a rejected pop, a reverse of fewer than two entries and the unused
// code need no wait state, so such words stream at one per cycle while results
// are taken. A pop waits in ST_POP_WAIT for the registered read of the entry
// memory. A reverse walks the mirrored pairs: each pair is read together and
// written back through the single write port of the memory, the low entry in
// ST_REV_LO and the high entry in ST_REV_HI. The stack contents start
// undefined and need no clearing after reset.
module lifo_stack_with_reverse_top
    import lsr_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // push_value
    input  logic [FUNC_W-1:0]   s_tuser,  // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // popped_value, occupancy, is_empty, status
);

    localparam int AW = $clog2(DEPTH);

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr_a;
    logic [AW-1:0]          rd_addr_b;
    logic [VALUE_WIDTH-1:0] rd_data_a;
    logic [VALUE_WIDTH-1:0] rd_data_b;
    result_t                result;

    assign m_tdata = {{(M_DATA_W - RESULT_W){1'b0}}, result};

    lsr_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_value   (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b)
    );

    lsr_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule

@@ rtl/lsr_mem.sv @@
// Entry memory of the stack: one write port and two read ports.
// Read data is registered and holds until the next read. No dependencies.
module lsr_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

@@ rtl/lsr_ctrl.sv @@
// Control of the stack: occupancy count, reverse walk indices, operation
// sequencer and the output register. Depends on lsr_pkg and drives lsr_mem.
module lsr_ctrl
    import lsr_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        in_func,
    input  logic [VALUE_W-1:0]       in_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output result_t                  out_result,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [VALUE_WIDTH-1:0]   wr_data,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [$clog2(DEPTH)-1:0] rd_addr_b,
    input  logic [VALUE_WIDTH-1:0]   rd_data_a,
    input  logic [VALUE_WIDTH-1:0]   rd_data_b
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                lo_reg, lo_next;
    logic [AW-1:0]                hi_reg, hi_next;
    logic                         out_valid_reg, out_valid_next;
    result_t                      res_reg, res_next;
    logic                         load_res;
    logic                         accept;
    logic [CW-1:0]                count_dec;
    logic [AW:0]                  walk_span;
    logic                         walk_more;
    status_t                      status;
    logic [VALUE_WIDTH-1:0]       popped;
    logic [VALUE_WIDTH+VALUE_W-1:0] popped_ext;
    logic [VALUE_W+VALUE_WIDTH-1:0] push_ext;
    logic [CW+OCC_W-1:0]          occ_ext;

    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign count_dec  = count_reg - CW'(1);
    assign walk_span  = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign walk_more  = walk_span > (AW + 1)'(2);
    assign push_ext   = {{VALUE_WIDTH{1'b0}}, in_value};
    assign popped_ext = {{VALUE_W{1'b0}}, popped};
    assign occ_ext    = {{OCC_W{1'b0}}, count_next};
    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_func == FUNC_POP && count_reg != '0)
                begin
                    state_next = ST_POP_WAIT;
                end
                else if (accept && in_func == FUNC_REVERSE && count_reg > CW'(1))
                begin
                    state_next = ST_REV_LO;
                end
            end
            ST_POP_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_REV_LO:
            begin
                state_next = ST_REV_HI;
            end
            ST_REV_HI:
            begin
                state_next = walk_more ? ST_REV_LO : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        rd_en      = 1'b0;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        load_res   = 1'b0;
        status     = STATUS_OK;
        popped     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_func)
                        FUNC_PUSH:
                        begin
                            load_res = 1'b1;
                            if (count_reg == FULL_COUNT)
                            begin
                                status = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = push_ext[VALUE_WIDTH-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FUNC_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                load_res = 1'b1;
                                status   = STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr_a  = count_dec[AW-1:0];
                                count_next = count_dec;
                            end
                        end
                        FUNC_REVERSE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                rd_en     = 1'b1;
                                rd_addr_a = '0;
                                rd_addr_b = count_dec[AW-1:0];
                                lo_next   = '0;
                                hi_next   = count_dec[AW-1:0];
                            end
                            else
                            begin
                                load_res = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_WAIT:
            begin
                load_res = 1'b1;
                popped   = rd_data_a;
            end
            ST_REV_LO:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = rd_data_b;
            end
            ST_REV_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = rd_data_a;
                if (walk_more)
                begin
                    rd_en     = 1'b1;
                    rd_addr_a = lo_reg + AW'(1);
                    rd_addr_b = hi_reg - AW'(1);
                    lo_next   = lo_reg + AW'(1);
                    hi_next   = hi_reg - AW'(1);
                end
                else
                begin
                    load_res = 1'b1;
                    lo_next  = '0;
                    hi_next  = '0;
                end
            end
            default:
            begin
                load_res = 1'b0;
            end
        endcase
        res_next.status       = status;
        res_next.is_empty     = (count_next == '0);
        res_next.occupancy    = occ_ext[OCC_W-1:0];
        res_next.popped_value = popped_ext[VALUE_W-1:0];
    end

    always_comb
    begin
        if (load_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

endmodule

@@ rtl/lsr_checker.sv @@
// Port-level checker for the LIFO stack with in-place reverse, with its bind
// to the top level. Depends on lsr_pkg.
module lsr_checker
    import lsr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [FUNC_W-1:0]   s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    result_t res;

    assign res = m_tdata[RESULT_W-1:0];

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.is_empty == (res.occupancy == '0)))
        else $error("Empty flag disagrees with occupancy.");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.status == STATUS_UNDERFLOW) |->
            (res.occupancy == '0 && res.popped_value == '0))
        else $error("Underflow reported on a nonempty stack.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.status == STATUS_OK || res.status == STATUS_UNDERFLOW ||
                      res.status == STATUS_OVERFLOW))
        else $error("Result word carries an undefined status.");

    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_PUSH) |=>
            (m_tvalid && res.popped_value == '0 && res.status != STATUS_UNDERFLOW))
        else $error("Push did not return its result in the next cycle.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("Stalled result word changed.");

endmodule

bind lifo_stack_with_reverse_top lsr_checker u_lsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/lifo_stack_with_reverse_top_tb.sv @@
// Self-checking testbench for lifo_stack_with_reverse_top.
// Streams push, pop and reverse words with random pacing and back pressure, and
// checks each result word against an in-bench model of the stack; depends on lsr_pkg.
module lifo_stack_with_reverse_top_tb;
    import lsr_pkg::*;

    localparam int STACK_DEPTH  = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 100;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]   s_tuser  = FUNC_PUSH;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    logic [VALUE_W-1:0] stack_mem [STACK_DEPTH];
    int                 stack_depth = 0;
    result_t            expected_results [$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 rx_hold_cycles = 0;
    int                 burst_left = 0;

    lifo_stack_with_reverse_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic result_t stack_apply(logic [FUNC_W-1:0] code,
                                            logic [VALUE_W-1:0] value);
        result_t            r;
        logic [VALUE_W-1:0] t;
        int                 hi;
        r.popped_value = '0;
        r.status       = STATUS_OK;
        case (code)
            FUNC_PUSH:
                if (stack_depth >= STACK_DEPTH)
                begin
                    r.status = STATUS_OVERFLOW;
                end
                else
                begin
                    stack_mem[stack_depth] = value;
                    stack_depth++;
                end
            FUNC_POP:
                if (stack_depth == 0)
                begin
                    r.status = STATUS_UNDERFLOW;
                end
                else
                begin
                    stack_depth--;
                    r.popped_value = stack_mem[stack_depth];
                end
            FUNC_REVERSE:
                for (int lo = 0; lo < stack_depth / 2; lo++)
                begin
                    hi            = stack_depth - 1 - lo;
                    t             = stack_mem[lo];
                    stack_mem[lo] = stack_mem[hi];
                    stack_mem[hi] = t;
                end
            default: ;
        endcase
        r.occupancy = OCC_W'(stack_depth);
        r.is_empty  = (stack_depth == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch in %s: got %h, expected %h (cycle %0d)",
                     what, got, want, cycle_count);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : track_and_check
        result_t            want;
        logic [VALUE_W-1:0] got_value;
        logic [OCC_W-1:0]   got_occ;
        logic               got_empty;
        logic [STATUS_W-1:0] got_status;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(stack_apply(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got_value  = m_tdata[VALUE_W-1:0];
                got_occ    = m_tdata[VALUE_W +: OCC_W];
                got_empty  = m_tdata[VALUE_W + OCC_W];
                got_status = m_tdata[VALUE_W + OCC_W + 1 +: STATUS_W];
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result word", got_value, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got_value != want.popped_value)
                        report_mismatch("popped_value", got_value, want.popped_value);
                    if (got_occ != want.occupancy)
                        report_mismatch("occupancy", VALUE_W'(got_occ),
                                        VALUE_W'(want.occupancy));
                    if (got_empty != want.is_empty)
                        report_mismatch("is_empty", VALUE_W'(got_empty),
                                        VALUE_W'(want.is_empty));
                    if (got_status != want.status)
                        report_mismatch("status", VALUE_W'(got_status),
                                        VALUE_W'(want.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : receiver
        logic [15:0] stall_mask;
        int          phase;
        stall_mask = '1;
        phase      = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (phase == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_mask = '1;
                        1: stall_mask = 16'($urandom) | 16'($urandom);
                        2: stall_mask = 16'($urandom);
                        default: stall_mask = 16'($urandom) & 16'($urandom);
                    endcase
                end
                m_tready <= stall_mask[phase];
                phase = (phase + 1) % 16;
            end
        end
    end

    task automatic send_word(logic [FUNC_W-1:0] code, logic [VALUE_W-1:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_word(FUNC_POP, '1);
        send_word(FUNC_REVERSE, '1);
        send_word(FUNC_UNUSED, '0);
        send_word(FUNC_PUSH, '0);
        send_word(FUNC_REVERSE, '0);
        send_word(FUNC_POP, '0);
        send_word(FUNC_PUSH, '1);
        send_word(FUNC_PUSH, '0);
        send_word(FUNC_PUSH, 32'h5555_5555);
        send_word(FUNC_PUSH, 32'hAAAA_AAAA);
        send_word(FUNC_REVERSE, 32'h1234_5678);
        send_word(FUNC_UNUSED, '1);
        send_word(FUNC_POP, '1);
        send_word(FUNC_POP, '0);
        send_word(FUNC_POP, '1);
        send_word(FUNC_POP, '0);
        send_word(FUNC_POP, '1);
        wait_for_results();
    endtask

    // Starts from an empty stack.
    task automatic test_full_stack();
        repeat (STACK_DEPTH) send_word(FUNC_PUSH, pick_value());
        send_word(FUNC_PUSH, '1);
        send_word(FUNC_PUSH, '0);
        send_word(FUNC_REVERSE, $urandom);
        repeat (10) send_word(FUNC_POP, $urandom);
        send_word(FUNC_REVERSE, $urandom);
        send_word(FUNC_POP, $urandom);
        send_word(FUNC_REVERSE, $urandom);
        repeat (STACK_DEPTH - 11 + 3) send_word(FUNC_POP, $urandom);
        wait_for_results();
    endtask

    task automatic test_random_mix(int count);
        int push_pct;
        int r;
        push_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    2: push_pct = 80;
                    default: push_pct = 95;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                send_word(FUNC_UNUSED, $urandom);
            else if (r < 13)
                send_word(FUNC_REVERSE, $urandom);
            else if ($urandom_range(0, 99) < push_pct)
                send_word(FUNC_PUSH, pick_value());
            else
                send_word(FUNC_POP, $urandom);
        end
    endtask

    task automatic test_back_pressure();
        rx_hold_cycles = HOLD_CYCLES;
        repeat (40) send_word(FUNC_PUSH, pick_value());
        wait_for_results();
        repeat (20) send_word(($urandom_range(0, 1) == 0) ? FUNC_POP : FUNC_REVERSE, $urandom);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_stack();
        test_random_mix(700);
        test_back_pressure();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
